@@ hdl/lfu_cache_lru_tiebreak_assert.svh @@
// Assertion macros used by the cache datapath.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Checked on every clock edge except while reset is held.
`define LCLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define LCLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/lclt_pkg.sv @@
// Shared constants, operation codes and controller interface types of the cache.
`timescale 1ns / 1ps

package lclt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request operation codes.
  localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HAS = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming item
    logic lookup;     // register the key match and clear the scan
    logic scan_step;  // examine one entry for victim and free slot
    logic commit;     // update the store and load the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // a set misses and may insert
    logic scan_last;  // the scan is at the last entry
    logic out_free;   // the result register can take a new item
  } ctrl_sts_t;

endpackage

@@ hdl/lclt_ctrl.sv @@
// Request sequencer of the cache: accept, look up, optional scan, commit.
`timescale 1ns / 1ps

module lclt_ctrl
  import lclt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = sts_i.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/lclt_dp.sv @@
// Datapath of the cache: entry store, key match, victim scan and result register.
`timescale 1ns / 1ps

module lclt_dp
  import lclt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  // Incoming item
  input  logic [FUNC_W-1:0] func_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [DATA_W-1:0] data_in_i,
  // Result item
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic              evicted_o,
  output logic [KEY_W-1:0]  evicted_key_o,
  // Controller link
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Entry store; each lane is read at its own place, the scan reads one entry.
  logic [ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]   key_q   [ENTRIES];
  logic [DATA_W-1:0]  value_q [ENTRIES];
  logic [COUNT_W-1:0] count_q [ENTRIES];
  logic [IDX_W-1:0]   rank_q  [ENTRIES];
  logic [OCC_W-1:0]   occ_q;
  logic [CAP_W-1:0]   cap_q;

  // Captured request.
  logic [FUNC_W-1:0]  req_func_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [DATA_W-1:0]  req_data_q;

  // Lookup results.
  logic [ENTRIES-1:0] match;
  logic               hit_d;
  logic [IDX_W-1:0]   hit_rank_d;
  logic [DATA_W-1:0]  hit_value_d;
  logic               hit_q;
  logic [ENTRIES-1:0] hit_oh_q;
  logic [IDX_W-1:0]   hit_rank_q;
  logic [DATA_W-1:0]  hit_value_q;

  // Scan state.
  logic [IDX_W-1:0]   scan_idx_q;
  logic               best_found_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [COUNT_W-1:0] best_count_q;
  logic [IDX_W-1:0]   best_rank_q;
  logic [KEY_W-1:0]   best_key_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic               scan_valid;
  logic [COUNT_W-1:0] scan_count;
  logic [IDX_W-1:0]   scan_rank;
  logic               scan_better;

  // Commit decisions.
  logic               cap_nz;
  logic               occ_full;
  logic               do_touch;
  logic               do_ins;
  logic               do_evict;
  logic               do_move;
  logic [IDX_W-1:0]   tgt_rank;

  // Result register.
  logic               out_valid_q;
  logic               out_hit_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_ev_q;
  logic [KEY_W-1:0]   out_evk_q;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q <= func_i;
      req_key_q  <= key_i;
      req_data_q <= data_in_i;
    end
  end

  // Parallel key compare; keys are unique, so the OR of lanes selects the hit entry.
  always_comb begin
    hit_rank_d  = '0;
    hit_value_d = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]    = valid_q[i] && (key_q[i] == req_key_q);
      hit_rank_d  = hit_rank_d  | (rank_q[i]  & {IDX_W{match[i]}});
      hit_value_d = hit_value_d | (value_q[i] & {DATA_W{match[i]}});
    end
    hit_d = |match;
  end

  assign cap_nz   = (cap_q != '0);
  assign occ_full = (CMP_W'(occ_q) >= CMP_W'(cap_q)) || (occ_q == OCC_W'(ENTRIES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q       <= hit_d;
      hit_oh_q    <= match;
      hit_rank_q  <= hit_rank_d;
      hit_value_q <= hit_value_d;
    end
  end

  // Scan one entry per cycle: lowest count, oldest among equals, and first free slot.
  assign scan_valid  = valid_q[scan_idx_q];
  assign scan_count  = count_q[scan_idx_q];
  assign scan_rank   = rank_q[scan_idx_q];
  assign scan_better = !best_found_q || (scan_count < best_count_q) ||
                       ((scan_count == best_count_q) && (scan_rank > best_rank_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      scan_idx_q   <= '0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (scan_valid && scan_better) begin
        best_found_q <= 1'b1;
      end
      if (!scan_valid) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (scan_valid && scan_better) begin
        best_idx_q   <= scan_idx_q;
        best_count_q <= scan_count;
        best_rank_q  <= scan_rank;
        best_key_q   <= key_q[scan_idx_q];
      end
      if (!scan_valid && !free_found_q) begin
        free_idx_q <= scan_idx_q;
      end
    end
  end

  // What the commit does to the store.
  assign do_touch = hit_q && ((req_func_q == FUNC_GET) || ((req_func_q == FUNC_SET) && cap_nz));
  assign do_ins   = (req_func_q == FUNC_SET) && !hit_q && cap_nz;
  assign do_evict = do_ins && occ_full;
  // Eviction followed by insert ages the entries exactly as a touch of the victim slot.
  assign do_move  = do_touch || do_evict;
  assign tgt_rank = do_touch ? hit_rank_q : best_rank_q;

  // Per-entry update lanes.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
    logic tgt_touch;
    logic tgt_new;

    assign tgt_touch = do_touch && hit_oh_q[i];
    assign tgt_new   = do_ins && (do_evict ? (best_idx_q == IDX_W'(i))
                                           : (free_idx_q == IDX_W'(i)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (cmd_i.commit && tgt_new) begin
        valid_q[i] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (tgt_new) begin
          key_q[i]   <= req_key_q;
          value_q[i] <= req_data_q;
          count_q[i] <= COUNT_W'(1);
          rank_q[i]  <= '0;
        end else if (tgt_touch) begin
          if (req_func_q == FUNC_SET) begin
            value_q[i] <= req_data_q;
          end
          if (count_q[i] != '1) begin
            count_q[i] <= count_q[i] + 1'b1;
          end
          rank_q[i] <= '0;
        end else if (valid_q[i]) begin
          if (do_move) begin
            if (rank_q[i] < tgt_rank) begin
              rank_q[i] <= rank_q[i] + 1'b1;
            end
          end else if (do_ins) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
  end

  // Occupancy grows only on an insert into a free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.commit && do_ins && !do_evict) begin
      occ_q <= occ_q + 1'b1;
    end
  end

  // Result register; a new item may be accepted while the result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q <= hit_q && (req_func_q != FUNC_NOP);
      if (req_func_q == FUNC_GET) begin
        out_data_q <= hit_q ? hit_value_q : '1;
      end else begin
        out_data_q <= '0;
      end
      out_ev_q  <= do_evict;
      out_evk_q <= do_evict ? best_key_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign data_out_o    = out_data_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evk_q;

  // Status to the controller.
  assign sts_o.need_scan = (req_func_q == FUNC_SET) && !hit_d && cap_nz;
  assign sts_o.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  `include "lfu_cache_lru_tiebreak_assert.svh"

  `LCLT_ASSERT_ALWAYS(a_occ_count, (!rst_ni || (OCC_W'($countones(valid_q)) == occ_q)), "occupancy count drifted")
  `LCLT_ASSERT(a_key_unique, $onehot0(match), "a key is stored in more than one entry")
  `LCLT_ASSERT(a_evict_miss, (cmd_i.commit && do_evict) |=> (out_ev_q && !out_hit_q), "eviction on a hit")
  `LCLT_ASSERT(a_insert_slot, (cmd_i.commit && do_ins) |-> (do_evict ? best_found_q : free_found_q), "insert without a slot")

endmodule

@@ hdl/lfu_cache_lru_tiebreak.sv @@
// Each item is accepted, looked up and committed into the result register for get, has,
// set on a present key and set with zero capacity; a set that inserts adds a slot scan
// before commit, which reads one entry per cycle for the victim and the first free slot.
// A new item is taken only after the last one commits; commit waits for a free result.
// Reset empties the store and sets capacity to 16; the block accepts items straight away.
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak
  import lclt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,   // capacity
  // Request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,  // [31:0] key, [63:32] data_in
  input  logic [1:0]       s_axis_tuser,  // [1:0] func
  // Result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [31:0] data_out, [63:32] evicted_key
  output logic [1:0]       m_axis_tuser   // [0] hit, [1] evicted
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      hit;
  logic      evicted;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  lclt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store and result path.
  lclt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (s_axis_tuser),
    .key_i         (s_axis_tdata[31:0]),
    .data_in_i     (s_axis_tdata[63:32]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .hit_o         (hit),
    .data_out_o    (m_axis_tdata[31:0]),
    .evicted_o     (evicted),
    .evicted_key_o (m_axis_tdata[63:32]),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  assign m_axis_tuser = {evicted, hit};

endmodule
